// ===== sv/mmsf_pkg.sv =====
// ----------------------------------------------------------------------------
// mmsf_pkg
// Shared types, codes and the byte-wise CRC-16/Modbus update for the
// motor speed framer.
// ----------------------------------------------------------------------------
package mmsf_pkg;

	localparam int unsigned FRAME_LEN = 8;
	localparam int unsigned POS_W     = $clog2(FRAME_LEN);

	// configuration register indexes
	localparam logic [7:0] CFG_DEVICE_ID = 8'd0;
	localparam logic [7:0] CFG_REG_ADDR  = 8'd1;

	localparam logic [7:0]  DEVICE_ID_RESET = 8'h00;
	localparam logic [15:0] REG_ADDR_RESET  = 16'h0001;

	localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;

	// one classified command, front to back
	typedef struct packed {
		logic        err;
		logic        brl;
		logic        brr;
		logic [7:0]  dev;
		logic [15:0] addr;
		logic [7:0]  neg_l;
		logic [7:0]  neg_r;
	} cmd_t;

	// reflected CRC-16, one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/mmsf_front.sv =====
// ----------------------------------------------------------------------------
// mmsf_front
// Accepts speed pairs, checks range, tracks brake flags, holds config and
// builds one command request for the back end.
// ----------------------------------------------------------------------------
module mmsf_front import mmsf_pkg::*; #(
	parameter int SPEED_LIMIT = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        q_push,
	output cmd_t        q_wdata,
	input  logic        q_full
);

	localparam logic signed [8:0] LIM_P = 9'(SPEED_LIMIT);
	localparam logic signed [8:0] LIM_N = 9'(-SPEED_LIMIT);

	logic [7:0]  dev_q;
	logic [15:0] addr_q;
	logic        brl_q;
	logic        brr_q;

	logic signed [8:0] left_x;
	logic signed [8:0] right_x;
	logic              bad;
	logic              nz_l;
	logic              nz_r;

	assign s_tready  = !q_full;
	assign cfg_ready = 1'b1;
	assign q_push    = s_tvalid && s_tready;

	assign left_x  = $signed({s_tdata[7], s_tdata[7:0]});
	assign right_x = $signed({s_tdata[15], s_tdata[15:8]});
	assign bad     = (left_x > LIM_P) || (left_x < LIM_N) ||
	                 (right_x > LIM_P) || (right_x < LIM_N);
	assign nz_l    = (s_tdata[7:0] != 8'h00);
	assign nz_r    = (s_tdata[15:8] != 8'h00);

	always_comb begin
		q_wdata.err   = bad;
		q_wdata.brl   = bad ? brl_q : nz_l;
		q_wdata.brr   = bad ? brr_q : nz_r;
		q_wdata.dev   = dev_q;
		q_wdata.addr  = addr_q;
		q_wdata.neg_l = 8'(8'h00 - s_tdata[7:0]);
		q_wdata.neg_r = 8'(8'h00 - s_tdata[15:8]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q  <= DEVICE_ID_RESET;
			addr_q <= REG_ADDR_RESET;
			brl_q  <= 1'b0;
			brr_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DEVICE_ID: dev_q  <= cfg_data[7:0];
					CFG_REG_ADDR:  addr_q <= cfg_data;
					default: ;
				endcase
			end
			if (q_push && !bad) begin
				brl_q <= nz_l;
				brr_q <= nz_r;
			end
		end
	end

endmodule

// ===== sv/mmsf_queue.sv =====
// ----------------------------------------------------------------------------
// mmsf_queue
// Small command FIFO between front and back.
// ----------------------------------------------------------------------------
module mmsf_queue import mmsf_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && valid) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push && !full, pop && valid})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/mmsf_back.sv =====
// ----------------------------------------------------------------------------
// mmsf_back
// Serializes one command into frame bytes, CRC folded in a byte per cycle while m_* is not stalled.
// ----------------------------------------------------------------------------
module mmsf_back import mmsf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_rdata,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic [2:0] m_tuser
);

	// first byte position that carries the CRC itself
	localparam logic [POS_W-1:0] CRC_LO_POS = POS_W'(FRAME_LEN - 2);

	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	logic [15:0]      crc_base;
	logic [7:0]       byte_c;
	logic             last_c;
	logic             take;

	assign take     = q_valid && (!m_tvalid || m_tready);
	assign last_c   = q_rdata.err || (pos_q == POS_W'(FRAME_LEN - 1));
	assign q_pop    = take && last_c;
	assign crc_base = (pos_q == '0) ? CRC_INIT : crc_q;

	always_comb begin
		case (pos_q)
			3'd0:    byte_c = q_rdata.dev;
			3'd1:    byte_c = FUNC_WRITE_SINGLE;
			3'd2:    byte_c = q_rdata.addr[15:8];
			3'd3:    byte_c = q_rdata.addr[7:0];
			3'd4:    byte_c = q_rdata.neg_l;
			3'd5:    byte_c = q_rdata.neg_r;
			3'd6:    byte_c = crc_q[7:0];
			default: byte_c = crc_q[15:8];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (take) begin
				m_tvalid <= 1'b1;
				pos_q    <= q_rdata.err ? '0 : pos_q + 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_tdata <= q_rdata.err ? 8'h00 : byte_c;
			m_tlast <= last_c;
			m_tuser <= {q_rdata.brr, q_rdata.brl, q_rdata.err};
		end
		// CRC holds once its own bytes go out
		if (take && (pos_q < CRC_LO_POS)) begin
			crc_q <= crc_byte(crc_base, byte_c);
		end
	end

endmodule

// ===== sv/modbus_motor_speed_framer_core.sv =====
// ----------------------------------------------------------------------------
// modbus_motor_speed_framer_core
// Wheel speed pair in, Modbus RTU write-single-register frame out, one byte
// per transfer, CRC-16/Modbus appended low byte first.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+----------------------------------
//  s_*       | in        | s_tvalid/s_tready  | s_tdata: left_speed, right_speed
//  m_*       | out       | m_tvalid/m_tready  | m_tdata, m_tlast, m_tuser
//  cfg_*     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  A valid command yields 8 frame bytes, one per output transfer; an out of
//  range command yields a single error byte. The byte serializer in the
//  back end produces these bytes.
//  The front takes a new request while the back is still sending, as long as
//  the command queue has room; an accepted request is written into the queue
//  and its first byte is then registered onto m_* by the back end.
//  m_tready low freezes the serializer; the queue then fills and s_tready drops.
//  Reset clears brake flags, config to device 0 / register 1, and the queue.
//
module modbus_motor_speed_framer_core import mmsf_pkg::*; #(
	parameter int SPEED_LIMIT = 100,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream: speed request
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] left_speed, [15:8] right_speed
	// master stream: frame bytes
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] tx_byte
	output logic        m_tlast,   // last_byte
	output logic [2:0]  m_tuser,   // [0] status, [1] brake_release_left,
	                               // [2] brake_release_right
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index, // 0 device_id, 1 register_address
	input  logic [15:0] cfg_data
);

	// front -> queue
	logic q_push;
	cmd_t q_wdata;
	logic q_full;
	// queue -> back
	logic q_valid;
	cmd_t q_rdata;
	logic q_pop;

	// range check, brake flags, config, speed negation
	mmsf_front #(
		.SPEED_LIMIT(SPEED_LIMIT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_push    (q_push),
		.q_wdata   (q_wdata),
		.q_full    (q_full)
	);

	// decouples intake from byte output
	mmsf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	// byte serializer with running CRC; output register on m_*
	mmsf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== tb/modbus_motor_speed_framer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_motor_speed_framer_core_tb
// Self-checking bench for the wheel speed framer. Speed requests go in on the
// slave stream and every frame byte that comes out is compared with a frame
// predicted on the side. The prediction covers the range check, the brake
// flags, the negated speeds and the CRC-16/Modbus. The bench also steps
// through several device id and register address settings and puts random
// gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module modbus_motor_speed_framer_core_tb;
	import mmsf_pkg::*;

	localparam int          SPEED_LIMIT   = 100;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT   = 200000;

	// writes to indexes past the register list must be dropped
	localparam logic [7:0] CFG_INDEX_UNUSED = 8'd2;
	localparam logic [7:0] CFG_INDEX_TOP    = 8'hFF;

	// output side stall behavior
	typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_BUSY} rx_mode_t;

	// one frame byte as seen on the master stream
	typedef struct packed {
		logic [7:0] tx;
		logic       last;
		logic       status;
		logic       brl;
		logic       brr;
	} frame_byte_t;

	// ------------------------------------------------------------------------
	// Frame predictor and checker. It keeps its own copy of the config and
	// the brake flags and queues the bytes each accepted request must yield.
	// ------------------------------------------------------------------------
	class frame_checker;
		logic [7:0]  device_id;
		logic [15:0] reg_addr;
		logic        left_released;
		logic        right_released;
		frame_byte_t expected_bytes[$];
		int unsigned errors;

		function new();
			device_id      = DEVICE_ID_RESET;
			reg_addr       = REG_ADDR_RESET;
			left_released  = 1'b0;
			right_released = 1'b0;
			errors         = 0;
		endfunction

		function void write_register(logic [7:0] index, logic [15:0] value);
			if (index == CFG_DEVICE_ID) begin
				device_id = value[7:0];
			end else if (index == CFG_REG_ADDR) begin
				reg_addr = value;
			end
		endfunction

		// accepted speed request: queue the error byte or the full frame
		function void add_request(logic [7:0] left, logic [7:0] right);
			int          l;
			int          r;
			logic [7:0]  frame [8];
			logic [15:0] crc;
			frame_byte_t b;
			l = $signed(left);
			r = $signed(right);
			if (l > SPEED_LIMIT || l < -SPEED_LIMIT || r > SPEED_LIMIT || r < -SPEED_LIMIT) begin
				// flags stay as they were, no frame
				b = '{tx: 8'h00, last: 1'b1, status: 1'b1,
				      brl: left_released, brr: right_released};
				expected_bytes.push_back(b);
				return;
			end
			left_released  = (l != 0);
			right_released = (r != 0);
			frame[0] = device_id;
			frame[1] = FUNC_WRITE_SINGLE;
			frame[2] = reg_addr[15:8];
			frame[3] = reg_addr[7:0];
			frame[4] = 8'h00 - left;
			frame[5] = 8'h00 - right;
			// reflected CRC over the six header and payload bytes
			crc = CRC_INIT;
			for (int i = 0; i < 6; i++) begin
				crc = crc ^ {8'h00, frame[i]};
				for (int k = 0; k < 8; k++) begin
					crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
				end
			end
			frame[6] = crc[7:0];
			frame[7] = crc[15:8];
			for (int i = 0; i < 8; i++) begin
				b = '{tx: frame[i], last: (i == 7), status: 1'b0,
				      brl: left_released, brr: right_released};
				expected_bytes.push_back(b);
			end
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				         $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_byte(logic [7:0] data, logic last, logic [2:0] user);
			frame_byte_t want;
			if (expected_bytes.size() == 0) begin
				$display("%0t ns: output byte %0h (last %0b, user %0b) with no request pending",
				         $time, data, last, user);
				errors++;
				return;
			end
			want = expected_bytes.pop_front();
			compare_field("tx_byte", want.tx, data);
			compare_field("last_byte", 8'(want.last), 8'(last));
			compare_field("status", 8'(want.status), 8'(user[0]));
			compare_field("brake_release_left", 8'(want.brl), 8'(user[1]));
			compare_field("brake_release_right", 8'(want.brr), 8'(user[2]));
		endfunction

		function int unsigned pending();
			return expected_bytes.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, DUT
	// ------------------------------------------------------------------------
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [2:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	rx_mode_t    rx_mode       = RX_STEADY;
	int unsigned rx_stall_left = 0;
	int unsigned cycle_count   = 0;

	frame_checker chk = new();

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	modbus_motor_speed_framer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Output side: stall pattern and byte checker
	// ------------------------------------------------------------------------
	// RX_LIGHT gives short random stalls, RX_BUSY long ones that back the
	// command queue up into s_tready.
	always @(posedge clk) begin
		if (rx_stall_left != 0) begin
			m_tready      <= 1'b0;
			rx_stall_left <= rx_stall_left - 1;
		end else if (rx_mode == RX_STEADY) begin
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 99) < ((rx_mode == RX_BUSY) ? 40 : 15)) begin
			m_tready      <= 1'b0;
			rx_stall_left <= $urandom_range(0, (rx_mode == RX_BUSY) ? 11 : 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			chk.check_byte(m_tdata, m_tlast, m_tuser);
		end
	end

	// hard stop in case the DUT hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus tasks
	// ------------------------------------------------------------------------
	// Holds the request until it is taken. s_tvalid stays high afterwards so
	// back-to-back requests follow without a gap; gaps lower it explicitly.
	task automatic send_speeds(input logic [7:0] left, input logic [7:0] right);
		s_tvalid <= 1'b1;
		s_tdata  <= {right, left};
		do @(posedge clk); while (!s_tready);
		chk.add_request(left, right);
	endtask

	// cfg_valid is left high for the next write; apply_settings lowers it
	task automatic cfg_write(input logic [7:0] index, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		chk.write_register(index, value);
	endtask

	// Only called with the DUT idle. The device id write carries random
	// upper bits, which must be dropped; the out-of-list write must be too.
	task automatic apply_settings(input logic [7:0] dev, input logic [15:0] addr,
	                              input logic [7:0] unused_index);
		cfg_write(CFG_DEVICE_ID, {8'($urandom), dev});
		cfg_write(CFG_REG_ADDR, addr);
		cfg_write(unused_index, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// stop sending, let every queued byte out, then let the pipe settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (chk.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly legal speeds, with zeros, the +/-SPEED_LIMIT edge and out-of-range values
	function automatic logic [7:0] pick_speed();
		int roll;
		int v;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			v = 0;
		end else if (roll < 16) begin
			v = $urandom_range(0, 1) ? SPEED_LIMIT : -SPEED_LIMIT;
		end else if (roll < 22) begin
			v = $urandom_range(SPEED_LIMIT + 1, 127);
			if ($urandom_range(0, 1)) v = -v;
		end else if (roll < 24) begin
			v = -128;
		end else begin
			v = $urandom_range(0, 2 * SPEED_LIMIT);
			v = v - SPEED_LIMIT;
		end
		return v[7:0];
	endfunction

	// Random requests, sent in bursts with gaps when gappy is set. With
	// pause_midway the sender waits once for the output to run dry.
	task automatic run_random(input int count, input bit gappy, input bit pause_midway);
		int burst_left;
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2) begin
				wait_drained();
			end
			if (gappy && burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst_left = $urandom_range(1, 8);
			end
			send_speeds(pick_speed(), pick_speed());
			if (burst_left > 0) burst_left--;
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests under the reset config, output always ready
		send_speeds(8'sd0, 8'sd0);          // both braked
		send_speeds(8'sd100, -8'sd100);     // limits, still legal
		send_speeds(-8'sd100, 8'sd100);
		send_speeds(8'sd50, 8'sd0);         // left released only
		send_speeds(8'sd101, 8'sd0);        // left just over, flags hold
		send_speeds(8'sd0, -8'sd101);       // right just under
		send_speeds(8'sd0, 8'sd50);         // right released only
		send_speeds(8'sd127, 8'sd127);      // largest positive, error
		send_speeds(8'h80, 8'sd0);          // -128, error
		send_speeds(8'sd0, 8'h80);
		send_speeds(8'h80, 8'h80);
		send_speeds(8'sd1, -8'sd1);
		send_speeds(-8'sd1, 8'sd1);
		send_speeds(8'sd85, -8'sd86);       // 0x55 / 0xAA patterns
		send_speeds(-8'sd100, -8'sd100);
		send_speeds(8'sd100, 8'sd100);
		send_speeds(-8'sd127, 8'sd10);      // error after a release
		send_speeds(8'sd0, 8'sd0);
		wait_drained();

		// top values, light stalls, bursty input
		apply_settings(8'hFF, 16'hFFFF, CFG_INDEX_UNUSED);
		rx_mode <= RX_LIGHT;
		run_random(25, 1'b1, 1'b0);
		wait_drained();

		// all zero, long stalls so the queue fills
		apply_settings(8'h00, 16'h0000, CFG_INDEX_TOP);
		rx_mode <= RX_BUSY;
		run_random(25, 1'b1, 1'b0);
		wait_drained();

		// random settings, no idling on either side, one drain midway
		apply_settings(8'($urandom), 16'($urandom), CFG_INDEX_UNUSED);
		rx_mode <= RX_STEADY;
		run_random(25, 1'b0, 1'b1);
		wait_drained();

		// mixed bit patterns, back pressure with input gaps
		apply_settings(8'hA5, 16'h5A3C, CFG_INDEX_TOP);
		rx_mode <= RX_BUSY;
		run_random(25, 1'b1, 1'b0);
		wait_drained();

		if (chk.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
